@@ design/iol_pkg.sv @@
package iol_pkg;

   localparam int FUNC_BITS  = 3;
   localparam int POS_BITS   = 5;
   localparam int DATA_BITS  = 32;
   localparam int COUNT_BITS = 5;

   localparam logic [FUNC_BITS-1:0] FUNC_APPEND     = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_INSERT     = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_REMOVE_VAL = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_READ_POS   = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_REMOVE_POS = 3'd4;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR      = 3'd5;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic [POS_BITS-1:0]  position;
      logic [DATA_BITS-1:0] value;
   } iol_req_type;

   typedef struct packed {
      logic                  status;
      logic [DATA_BITS-1:0]  read_value;
      logic [COUNT_BITS-1:0] entry_count;
   } iol_rsp_type;

endpackage

@@ design/iol_chan_if.sv @@
interface iol_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ design/indexed_ordered_list_unit.sv @@
// Indexed ordered list: keeps up to CAPACITY words in order plus a count.
// req_chan carries one item per request (func, position, value); rsp_chan
// returns exactly one item per request (status, read_value, entry_count).
// Both channels move an item on a clock edge where valid and ready are high.
// Operations run on one list memory (one write port, one registered read
// port) under a small sequencer with a single index incrementer/decrementer;
// each moved entry costs a read step and a write step.
// Steps per request: clear, failures and unused codes go straight to
// the finishing step; append and insert at position p move entries up
// one place from the end down to p, then write the new word there; read
// at position fetches the entry and takes its value; remove at position
// p takes the entry, then moves entries down one place from p to the end;
// remove by value compares entries from the start and, on a match,
// closes the gap the same way; a miss ends at the finishing step.
// req_chan.ready is high only while the sequencer is idle, so one item is
// in work at a time. The result sits in an output register; a new item is
// taken while that result still waits, and a stalled receiver only holds
// the finishing step. Synchronous reset empties the list (count to zero)
// and drops any pending result; the memory itself is not cleared.
module indexed_ordered_list_unit #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   iol_chan_if.sink   req_chan,
   iol_chan_if.source rsp_chan
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int XW = (CW > iol_pkg::POS_BITS) ? CW : iol_pkg::POS_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_WR,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_FETCH,
      ST_TAKE,
      ST_DN_RD,
      ST_DN_WR,
      ST_DONE
   } state_type;

   state_type                          state_ff;
   logic [CW-1:0]                      cnt_ff;
   logic [CW-1:0]                      idx_ff;
   logic [CW-1:0]                      pos_ff;
   logic [VALUE_BITS-1:0]              val_ff;
   logic [iol_pkg::FUNC_BITS-1:0]      func_ff;
   logic                               status_ff;
   logic [iol_pkg::DATA_BITS-1:0]      rv_ff;
   logic                               rsp_valid_ff;
   iol_pkg::iol_rsp_type               rsp_data_ff;

   logic [VALUE_BITS-1:0]              mem_ff [CAPACITY];
   logic [VALUE_BITS-1:0]              rd_data_ff;

   logic                               mem_we;
   logic [AW-1:0]                      mem_wa;
   logic [VALUE_BITS-1:0]              mem_wd;
   logic [AW-1:0]                      mem_ra;

   logic [CW-1:0]                      idx_step;
   logic [XW-1:0]                      pos_x;
   logic [XW-1:0]                      cnt_x;
   logic                               list_full;
   logic                               req_accept;
   logic                               out_free;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign pos_x     = XW'(req_chan.data.position);
   assign cnt_x     = XW'(cnt_ff);
   assign list_full = (cnt_ff == CW'(CAPACITY));

   // Shared index unit: step down while opening a gap, up otherwise.
   assign idx_step = (state_ff == ST_UP_RD || state_ff == ST_UP_WR) ?
                     idx_ff - CW'(1) : idx_ff + CW'(1);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = idx_ff[AW-1:0];
      mem_wd = rd_data_ff;
      mem_ra = idx_ff[AW-1:0];
      unique case (state_ff)
         ST_UP_RD: begin
            mem_ra = idx_step[AW-1:0];
            if (idx_ff == pos_ff) begin
               // gap reached: drop the new word in
               mem_we = 1'b1;
               mem_wd = val_ff;
            end
         end
         ST_UP_WR, ST_DN_WR: begin
            mem_we = 1'b1;
         end
         ST_DN_RD: begin
            mem_ra = idx_step[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // retire the held result once the receiver takes it; the finishing
         // step loads the register itself
         if (rsp_valid_ff && rsp_chan.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  func_ff   <= req_chan.data.func;
                  val_ff    <= VALUE_BITS'(req_chan.data.value);
                  rv_ff     <= '0;
                  // clear always succeeds; everything else starts out failed
                  status_ff <= (req_chan.data.func == iol_pkg::FUNC_CLEAR) ?
                               iol_pkg::STATUS_OK : iol_pkg::STATUS_FAIL;
                  unique case (req_chan.data.func)
                     iol_pkg::FUNC_APPEND: begin
                        if (!list_full) begin
                           idx_ff   <= cnt_ff;
                           pos_ff   <= cnt_ff;
                           state_ff <= ST_UP_RD;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     iol_pkg::FUNC_INSERT: begin
                        if (!list_full && pos_x <= cnt_x) begin
                           idx_ff   <= cnt_ff;
                           pos_ff   <= CW'(req_chan.data.position);
                           state_ff <= ST_UP_RD;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     iol_pkg::FUNC_REMOVE_VAL: begin
                        idx_ff   <= '0;
                        state_ff <= ST_SRCH_RD;
                     end
                     iol_pkg::FUNC_READ_POS, iol_pkg::FUNC_REMOVE_POS: begin
                        if (pos_x < cnt_x) begin
                           idx_ff   <= CW'(req_chan.data.position);
                           state_ff <= ST_FETCH;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     iol_pkg::FUNC_CLEAR: begin
                        cnt_ff   <= '0;
                        state_ff <= ST_DONE;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end

            ST_UP_RD: begin
               if (idx_ff == pos_ff) begin
                  cnt_ff    <= cnt_ff + CW'(1);
                  status_ff <= iol_pkg::STATUS_OK;
                  state_ff  <= ST_DONE;
               end else begin
                  state_ff <= ST_UP_WR;
               end
            end

            ST_UP_WR: begin
               // entry below moved up into idx; advance down
               idx_ff   <= idx_step;
               state_ff <= ST_UP_RD;
            end

            ST_SRCH_RD: begin
               if (idx_ff == cnt_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_SRCH_CMP;
               end
            end

            ST_SRCH_CMP: begin
               if (rd_data_ff == val_ff) begin
                  state_ff <= ST_DN_RD;
               end else begin
                  idx_ff   <= idx_step;
                  state_ff <= ST_SRCH_RD;
               end
            end

            ST_FETCH: begin
               state_ff <= ST_TAKE;
            end

            ST_TAKE: begin
               rv_ff <= iol_pkg::DATA_BITS'(rd_data_ff);
               if (func_ff == iol_pkg::FUNC_READ_POS) begin
                  status_ff <= iol_pkg::STATUS_OK;
                  state_ff  <= ST_DONE;
               end else begin
                  state_ff <= ST_DN_RD;
               end
            end

            ST_DN_RD: begin
               if (idx_step == cnt_ff) begin
                  // last entry reached: close the list
                  cnt_ff    <= cnt_ff - CW'(1);
                  status_ff <= iol_pkg::STATUS_OK;
                  state_ff  <= ST_DONE;
               end else begin
                  state_ff <= ST_DN_WR;
               end
            end

            ST_DN_WR: begin
               idx_ff   <= idx_step;
               state_ff <= ST_DN_RD;
            end

            ST_DONE: begin
               // hold here until the output register is free
               if (out_free) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.status      <= status_ff;
                  rsp_data_ff.read_value  <= rv_ff;
                  rsp_data_ff.entry_count <= cnt_x[iol_pkg::COUNT_BITS-1:0];
                  state_ff                <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ design/iol_checker.sv @@
module iol_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_status,
   input logic [iol_pkg::DATA_BITS-1:0]         rsp_read_value,
   input logic [iol_pkg::COUNT_BITS-1:0]        rsp_entry_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_read_value) && $stable(rsp_entry_count))
      else $error("rsp item changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == iol_pkg::STATUS_FAIL |-> rsp_read_value == '0)
      else $error("failed item carries a nonzero value");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous item in work");

   a_reset_drop: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind indexed_ordered_list_unit iol_checker u_iol_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.data.status),
   .rsp_read_value  (rsp_chan.data.read_value),
   .rsp_entry_count (rsp_chan.data.entry_count)
);
